// File: src/dra_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the damage rect accumulator
package dra_pkg;

   localparam int DEF_MAX_RECTS  = 64;
   localparam int DEF_COORD_BITS = 14;

   localparam int CW        = 14;   // coordinate field width
   localparam int IN_W      = 16;   // signed input coordinate width
   localparam int CMD_W     = 2;
   localparam int CNT_OUT_W = 7;

   localparam logic [CW-1:0] RST_WIDTH  = 14'd1920;
   localparam logic [CW-1:0] RST_HEIGHT = 14'd1080;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_FULL  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLIP,
      ST_ENTRY,
      ST_SCAN_RD,
      ST_EVAL,
      ST_AREA,
      ST_DECIDE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_SHIFT_DONE,
      ST_RESP,
      ST_RO_RD,
      ST_RO_EMIT
   } state_type;

   typedef struct packed {
      logic load_req;
      logic clear;
      logic go_full;
      logic clip;
      logic merge_fill;
      logic idx_clr;
      logic idx_inc;
      logic rd_scan;
      logic rd_shift;
      logic eval;
      logic area;
      logic load_union;
      logic shift_wr;
      logic cnt_dec;
      logic append;
      logic emit_status;
      logic emit_rect;
   } ctrl_cmd_type;

   typedef struct packed {
      logic full;
      logic size_zero;
      logic r_empty;
      logic r_covers;
      logic idx_lt_cnt;
      logic idx1_lt_cnt;
      logic idx2_lt_cnt;
      logic cnt_full;
      logic cnt_zero;
      logic s_holds_r;
      logic merge_ok;
      logic out_free;
   } dp_stat_type;

endpackage

// File: src/dra_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine of the damage rect accumulator
module dra_ctrl import dra_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [CMD_W-1:0]  req_command,
   output logic              req_stall,
   input  dp_stat_type       stat,
   output ctrl_cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               case (cmd_type'(req_command))
                  CMD_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = ST_RESP;
                  end
                  CMD_ADD: begin
                     state_in = ST_CLIP;
                  end
                  CMD_FULL: begin
                     cmd.go_full = 1'b1;
                     state_in    = ST_RESP;
                  end
                  default: begin
                     cmd.idx_clr = 1'b1;
                     state_in    = stat.cnt_zero ? ST_RESP : ST_RO_RD;
                  end
               endcase
            end
         end
         ST_CLIP: begin
            if (stat.full || stat.size_zero) begin
               // fill request still counts while the frame is full damage
               cmd.merge_fill = stat.full;
               state_in       = ST_RESP;
            end else begin
               cmd.clip = 1'b1;
               state_in = ST_ENTRY;
            end
         end
         ST_ENTRY: begin
            if (stat.r_empty) begin
               state_in = ST_RESP;
            end else begin
               cmd.merge_fill = 1'b1;
               if (stat.r_covers) begin
                  cmd.go_full = 1'b1;
                  state_in    = ST_RESP;
               end else begin
                  cmd.idx_clr = 1'b1;
                  state_in    = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            if (stat.idx_lt_cnt) begin
               cmd.rd_scan = 1'b1;
               state_in    = ST_EVAL;
            end else begin
               if (stat.cnt_full) begin
                  cmd.go_full = 1'b1;
               end else begin
                  cmd.append = 1'b1;
               end
               state_in = ST_RESP;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_AREA;
         end
         ST_AREA: begin
            cmd.area = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (stat.s_holds_r) begin
               state_in = ST_RESP;
            end else if (stat.merge_ok) begin
               cmd.load_union = 1'b1;
               state_in       = stat.idx1_lt_cnt ? ST_SHIFT_RD : ST_SHIFT_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            cmd.rd_shift = 1'b1;
            state_in     = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = stat.idx2_lt_cnt ? ST_SHIFT_RD : ST_SHIFT_DONE;
         end
         ST_SHIFT_DONE: begin
            cmd.cnt_dec = 1'b1;
            if (stat.r_covers) begin
               cmd.go_full = 1'b1;
               state_in    = ST_RESP;
            end else begin
               cmd.idx_clr = 1'b1;
               state_in    = ST_SCAN_RD;
            end
         end
         ST_RESP: begin
            if (stat.out_free) begin
               cmd.emit_status = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_RO_RD: begin
            cmd.rd_scan = 1'b1;
            state_in    = ST_RO_EMIT;
         end
         ST_RO_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_rect = 1'b1;
               cmd.idx_inc   = 1'b1;
               state_in      = stat.idx1_lt_cnt ? ST_RO_RD : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // an accepted item always leaves idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start work");

endmodule

// File: src/dra_datapath.sv
`timescale 1ns / 1ps
// rect store, working rect, merge arithmetic and output register
module dra_datapath import dra_pkg::*; #(
   parameter int MAX_RECTS  = DEF_MAX_RECTS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_stat_type           stat,
   input  logic signed [IN_W-1:0] req_rect_left,
   input  logic signed [IN_W-1:0] req_rect_top,
   input  logic signed [IN_W-1:0] req_rect_w,
   input  logic signed [IN_W-1:0] req_rect_h,
   input  logic                  req_needs_fill,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CW-1:0]         csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CW-1:0]         rsp_out_left,
   output logic [CW-1:0]         rsp_out_top,
   output logic [CW-1:0]         rsp_out_w,
   output logic [CW-1:0]         rsp_out_h,
   output logic                  rsp_rect_valid,
   output logic                  rsp_full_damage,
   output logic                  rsp_fill_needed,
   output logic [CNT_OUT_W-1:0]  rsp_rect_count,
   output logic                  rsp_last
);

   localparam int CNT_W = $clog2(MAX_RECTS + 1);
   localparam int IDX_W = $clog2(MAX_RECTS);
   localparam int ENT_W = 4 * CW;
   localparam int AR_W  = 2 * CW;
   localparam int UA_W  = 2 * CW + 2;
   localparam int CMP_W = 2 * CW + 6;
   localparam logic [CW-1:0]    CMASK   = CW'((1 << COORD_BITS) - 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECTS);

   function automatic logic [CW-1:0] clamp_s(input logic signed [IN_W:0] v,
                                             input logic [CW-1:0] hi);
      logic signed [IN_W:0] hs;
      hs = $signed({{(IN_W + 1 - CW){1'b0}}, hi});
      if (v < 0) return '0;
      else if (v > hs) return hi;
      else return v[CW-1:0];
   endfunction

   function automatic logic [CW-1:0] clamp_u(input logic [CW:0] v,
                                             input logic [CW-1:0] hi);
      if (v > {1'b0, hi}) return hi;
      else return v[CW-1:0];
   endfunction

   // configuration
   logic [CW-1:0] cw_ff, ch_ff;

   // captured item
   logic signed [IN_W-1:0] in_x_ff, in_y_ff, in_w_ff, in_h_ff;
   logic                   in_fill_ff;

   // working rect as edges
   logic [CW-1:0] rl_ff, rt_ff, rr_ff, rb_ff;
   logic [CW-1:0] rl_in, rt_in, rr_in, rb_in;

   // frame state
   logic [CNT_W-1:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic             full_ff, full_in, fill_ff, fill_in;

   // store
   logic [ENT_W-1:0] rect_store_ff [MAX_RECTS];
   logic [ENT_W-1:0] rd_ff;
   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [ENT_W-1:0] wr_data;
   logic [CNT_W:0]   idx_p1, idx_p2;

   // compare stage
   logic [CW-1:0] sx, sy, sw, sh;
   logic [CW:0]   s_r, s_b;
   logic [CW-1:0] sw_ff, sh_ff, ul_ff, ut_ff;
   logic [CW:0]   ur_ff, ub_ff;
   logic          shr_ff, rhs_ff;

   // area stage
   logic [AR_W-1:0]  s_area_ff, r_area_ff;
   logic [UA_W-1:0]  u_area_ff;
   logic [CW:0]      uw, uh;
   logic [CMP_W-1:0] both, lhs, rhs;

   // clip of the captured item
   logic signed [IN_W:0] sum_x, sum_y;

   // output register
   logic                 rsp_valid_ff;
   logic [CW-1:0]        o_l_ff, o_t_ff, o_w_ff, o_h_ff;
   logic                 o_rv_ff, o_full_ff, o_fill_ff, o_last_ff;
   logic [CNT_OUT_W-1:0] o_cnt_ff;
   logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;
   logic                 out_free;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff <= RST_WIDTH & CMASK;
         ch_ff <= RST_HEIGHT & CMASK;
      end else if (csr_valid) begin
         if (reg_idx_type'(csr_index) == REG_WIDTH) begin
            cw_ff <= csr_wdata & CMASK;
         end else begin
            ch_ff <= csr_wdata & CMASK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         in_x_ff    <= req_rect_left;
         in_y_ff    <= req_rect_top;
         in_w_ff    <= req_rect_w;
         in_h_ff    <= req_rect_h;
         in_fill_ff <= req_needs_fill;
      end
   end

   assign sum_x = {in_x_ff[IN_W-1], in_x_ff} + {in_w_ff[IN_W-1], in_w_ff};
   assign sum_y = {in_y_ff[IN_W-1], in_y_ff} + {in_h_ff[IN_W-1], in_h_ff};

   always_comb begin
      rl_in = rl_ff;
      rt_in = rt_ff;
      rr_in = rr_ff;
      rb_in = rb_ff;
      if (cmd.clip) begin
         rl_in = clamp_s({in_x_ff[IN_W-1], in_x_ff}, cw_ff);
         rt_in = clamp_s({in_y_ff[IN_W-1], in_y_ff}, ch_ff);
         rr_in = clamp_s(sum_x, cw_ff);
         rb_in = clamp_s(sum_y, ch_ff);
      end else if (cmd.load_union) begin
         rl_in = ul_ff;
         rt_in = ut_ff;
         rr_in = clamp_u(ur_ff, cw_ff);
         rb_in = clamp_u(ub_ff, ch_ff);
      end
   end

   always_ff @(posedge clock) begin
      rl_ff <= rl_in;
      rt_ff <= rt_in;
      rr_ff <= rr_in;
      rb_ff <= rb_in;
   end

   // frame counters and flags; full damage wins over everything else
   always_comb begin
      cnt_in  = cnt_ff;
      full_in = full_ff;
      fill_in = fill_ff;
      idx_in  = idx_ff;
      if (cmd.idx_clr) idx_in = '0;
      else if (cmd.idx_inc) idx_in = idx_ff + 1'b1;
      if (cmd.merge_fill) fill_in = fill_ff | in_fill_ff;
      if (cmd.cnt_dec) cnt_in = cnt_ff - 1'b1;
      if (cmd.append) cnt_in = cnt_ff + 1'b1;
      if (cmd.clear) begin
         cnt_in  = '0;
         full_in = 1'b0;
         fill_in = 1'b0;
      end
      if (cmd.go_full) begin
         full_in = (cw_ff != '0) && (ch_ff != '0);
         fill_in = full_in;
         cnt_in  = full_in ? CNT_W'(1) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         full_ff <= 1'b0;
         fill_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         full_ff <= full_in;
         fill_ff <= fill_in;
         idx_ff  <= idx_in;
      end
   end

   // store port control
   assign idx_p1  = {1'b0, idx_ff} + 1'b1;
   assign idx_p2  = {1'b0, idx_ff} + 2'd2;
   assign rd_en   = cmd.rd_scan | cmd.rd_shift;
   assign rd_addr = cmd.rd_shift ? idx_p1[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_en   = cmd.go_full | cmd.shift_wr | cmd.append;

   always_comb begin
      wr_addr = idx_ff[IDX_W-1:0];
      wr_data = rd_ff;
      if (cmd.go_full) begin
         wr_addr = '0;
         wr_data = {{(2 * CW){1'b0}}, cw_ff, ch_ff};
      end else if (cmd.append) begin
         wr_addr = cnt_ff[IDX_W-1:0];
         wr_data = {rl_ff, rt_ff, rr_ff - rl_ff, rb_ff - rt_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) rect_store_ff[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= rect_store_ff[rd_addr];
   end

   // containment and union of stored rect against working rect
   assign {sx, sy, sw, sh} = rd_ff;
   assign s_r = {1'b0, sx} + {1'b0, sw};
   assign s_b = {1'b0, sy} + {1'b0, sh};

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         sw_ff  <= sw;
         sh_ff  <= sh;
         shr_ff <= (sx <= rl_ff) && (sy <= rt_ff) &&
                   (s_r >= {1'b0, rr_ff}) && (s_b >= {1'b0, rb_ff});
         rhs_ff <= (rl_ff <= sx) && (rt_ff <= sy) &&
                   ({1'b0, rr_ff} >= s_r) && ({1'b0, rb_ff} >= s_b);
         ul_ff  <= (sx < rl_ff) ? sx : rl_ff;
         ut_ff  <= (sy < rt_ff) ? sy : rt_ff;
         ur_ff  <= (s_r > {1'b0, rr_ff}) ? s_r : {1'b0, rr_ff};
         ub_ff  <= (s_b > {1'b0, rb_ff}) ? s_b : {1'b0, rb_ff};
      end
   end

   assign uw = ur_ff - {1'b0, ul_ff};
   assign uh = ub_ff - {1'b0, ut_ff};

   always_ff @(posedge clock) begin
      if (cmd.area) begin
         s_area_ff <= sw_ff * sh_ff;
         r_area_ff <= (rr_ff - rl_ff) * (rb_ff - rt_ff);
         u_area_ff <= uw * uh;
      end
   end

   // waste within a fifth: 5 * union <= 6 * (sum of areas)
   assign both = CMP_W'(s_area_ff) + CMP_W'(r_area_ff);
   assign lhs  = (CMP_W'(u_area_ff) << 2) + CMP_W'(u_area_ff);
   assign rhs  = (both << 2) + (both << 1);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      stat.full        = full_ff;
      stat.size_zero   = (cw_ff == '0) || (ch_ff == '0);
      stat.r_empty     = (rr_ff <= rl_ff) || (rb_ff <= rt_ff);
      stat.r_covers    = (rl_ff == '0) && (rt_ff == '0) &&
                         (rr_ff == cw_ff) && (rb_ff == ch_ff);
      stat.idx_lt_cnt  = idx_ff < cnt_ff;
      stat.idx1_lt_cnt = idx_p1 < {1'b0, cnt_ff};
      stat.idx2_lt_cnt = idx_p2 < {1'b0, cnt_ff};
      stat.cnt_full    = cnt_ff >= CNT_MAX;
      stat.cnt_zero    = cnt_ff == '0;
      stat.s_holds_r   = shr_ff;
      stat.merge_ok    = rhs_ff || ((both != '0) && (lhs <= rhs));
      stat.out_free    = out_free;
   end

   // output register
   assign cnt_ext = {{CNT_OUT_W{1'b0}}, cnt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_status || cmd.emit_rect) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_status || cmd.emit_rect) begin
         o_l_ff    <= cmd.emit_rect ? sx : '0;
         o_t_ff    <= cmd.emit_rect ? sy : '0;
         o_w_ff    <= cmd.emit_rect ? sw : '0;
         o_h_ff    <= cmd.emit_rect ? sh : '0;
         o_rv_ff   <= cmd.emit_rect;
         o_full_ff <= full_ff;
         o_fill_ff <= fill_ff;
         o_cnt_ff  <= cnt_ext[CNT_OUT_W-1:0];
         o_last_ff <= cmd.emit_status || !stat.idx1_lt_cnt;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_left    = o_l_ff;
   assign rsp_out_top     = o_t_ff;
   assign rsp_out_w       = o_w_ff;
   assign rsp_out_h       = o_h_ff;
   assign rsp_rect_valid  = o_rv_ff;
   assign rsp_full_damage = o_full_ff;
   assign rsp_fill_needed = o_fill_ff;
   assign rsp_rect_count  = o_cnt_ff;
   assign rsp_last        = o_last_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("rect count above store depth");

   a_full_single: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (fill_ff && (cnt_ff == CNT_W'(1))))
      else $error("full damage without single rect and fill");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_status || cmd.emit_rect) |-> out_free)
      else $error("result overwrote an untaken item");

endmodule

// File: src/damage_rect_accumulator.sv
`timescale 1ns / 1ps
// top level of the damage rect accumulator
// Collects damage rects for one frame in an ordered store of MAX_RECTS
// entries held in a memory with separate read and write ports and
// registered read, which sets the pace: stored rects are looked at one at a
// time, each through the read, compare, area and decide states. In an add,
// each merge moves the entries behind the merged rect down when it is
// removed, after which the scan starts again from the first entry. A read
// out gives the stored rects in order. One item is worked on at a time; the
// result sits in an output register, so the next item is taken while the
// previous result still waits. No clearing pass after reset.
module damage_rect_accumulator import dra_pkg::*; #(
   parameter int MAX_RECTS  = DEF_MAX_RECTS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   // item in
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [CMD_W-1:0]       req_command,
   input  logic signed [IN_W-1:0] req_rect_left,
   input  logic signed [IN_W-1:0] req_rect_top,
   input  logic signed [IN_W-1:0] req_rect_w,
   input  logic signed [IN_W-1:0] req_rect_h,
   input  logic                   req_needs_fill,
   // register writes, index 0 width, 1 height
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [CW-1:0]          csr_wdata,
   // item out
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CW-1:0]          rsp_out_left,
   output logic [CW-1:0]          rsp_out_top,
   output logic [CW-1:0]          rsp_out_w,
   output logic [CW-1:0]          rsp_out_h,
   output logic                   rsp_rect_valid,
   output logic                   rsp_full_damage,
   output logic                   rsp_fill_needed,
   output logic [CNT_OUT_W-1:0]   rsp_rect_count,
   output logic                   rsp_last
);

   // command and status between sequencer and datapath
   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   dra_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .stat        (stat),
      .cmd         (cmd)
   );

   dra_datapath #(
      .MAX_RECTS  (MAX_RECTS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_rect_left   (req_rect_left),
      .req_rect_top    (req_rect_top),
      .req_rect_w      (req_rect_w),
      .req_rect_h      (req_rect_h),
      .req_needs_fill  (req_needs_fill),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_left    (rsp_out_left),
      .rsp_out_top     (rsp_out_top),
      .rsp_out_w       (rsp_out_w),
      .rsp_out_h       (rsp_out_h),
      .rsp_rect_valid  (rsp_rect_valid),
      .rsp_full_damage (rsp_full_damage),
      .rsp_fill_needed (rsp_fill_needed),
      .rsp_rect_count  (rsp_rect_count),
      .rsp_last        (rsp_last)
   );

endmodule
